// File: hw/rtl/bapm_pkg.sv
// ----------------------------------------------------------------------------
// bapm_pkg
// shared widths, codes and types of the buffer age pool manager
// ----------------------------------------------------------------------------
package bapm_pkg;

    localparam int MAX_SLOTS = 4;
    localparam int AGE_BITS  = 8;

    localparam int IDX_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int OP_W       = 3;
    localparam int REL_W      = 2;
    localparam int DIM_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int SURPLUS_W  = 8;
    localparam int TRIM_W     = 8;
    localparam int LIMIT_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [AGE_BITS-1:0]  AGE_MAX     = '1;
    localparam logic [SURPLUS_W-1:0] SURPLUS_MAX = '1;

    localparam logic [TRIM_W-1:0]  TRIM_RESET  = TRIM_W'(100);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

    localparam logic [OP_W-1:0] OP_ASSIGN   = 3'd0;
    localparam logic [OP_W-1:0] OP_POST     = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RECONFIG = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BUFFER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

    typedef logic [AGE_BITS-1:0] t_age;
    typedef logic [IDX_W-1:0]    t_idx;

    typedef enum logic [3:0] {
        DC_NONE,
        DC_LOAD,
        DC_SCAN,
        DC_FINISH,
        DC_POST,
        DC_RELEASE,
        DC_SWEEP,
        DC_IGNORE,
        DC_EMIT
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd cmd;
        t_idx    idx;
    } t_dp_ctrl;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            size_zero;
        logic            trim;
    } t_dp_stat;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        t_idx                 slot;
        logic                 slot_valid;
        t_age                 age;
        logic                 created;
        logic [MAX_SLOTS-1:0] destroyed_mask;
    } t_result;

    function automatic t_age age_inc(input t_age a);
        return (a == AGE_MAX) ? a : a + t_age'(1);
    endfunction

endpackage

// File: hw/rtl/bapm_channels.sv
// ----------------------------------------------------------------------------
// bapm channels
// valid/ready channels for operations, results and register writes
// ----------------------------------------------------------------------------
interface bapm_in_if import bapm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [REL_W-1:0] release_slot;
    logic             purge;
    logic [DIM_W-1:0] new_width;
    logic [DIM_W-1:0] new_height;

    modport source (output valid, operation, release_slot, purge, new_width, new_height,
                    input ready);
    modport sink   (input valid, operation, release_slot, purge, new_width, new_height,
                    output ready);
endinterface

interface bapm_out_if import bapm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    t_idx                 slot;
    logic                 slot_valid;
    t_age                 age;
    logic                 created;
    logic [MAX_SLOTS-1:0] destroyed_mask;

    modport source (output valid, status, slot, slot_valid, age, created, destroyed_mask,
                    input ready);
    modport sink   (input valid, status, slot, slot_valid, age, created, destroyed_mask,
                    output ready);
endinterface

interface bapm_cfg_if import bapm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bapm_ctrl.sv
// ----------------------------------------------------------------------------
// bapm_ctrl
// operation sequencer: decode, trim scan loop, destroy sweep, result hand-off
// ----------------------------------------------------------------------------
module bapm_ctrl import bapm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_FINISH = 6'b001000,
        S_SWEEP  = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    localparam t_idx LAST_IDX = t_idx'(MAX_SLOTS - 1);

    t_state r_state, n_state;
    t_idx   r_idx, n_idx;
    logic   r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_ctrl.cmd  = DC_NONE;
        o_ctrl.idx  = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.cmd = DC_LOAD;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_ASSIGN: begin
                        n_state = S_SCAN;
                    end
                    OP_POST: begin
                        o_ctrl.cmd = DC_POST;
                        n_state    = S_EMIT;
                    end
                    OP_RELEASE: begin
                        o_ctrl.cmd = DC_RELEASE;
                        n_state    = S_EMIT;
                    end
                    OP_RECONFIG: begin
                        if (i_stat.size_zero) begin
                            o_ctrl.cmd = DC_IGNORE;
                            n_state    = S_EMIT;
                        end else begin
                            n_idx   = '0;
                            n_state = S_SWEEP;
                        end
                    end
                    OP_FLUSH: begin
                        n_idx   = '0;
                        n_state = S_SWEEP;
                    end
                    default: begin
                        o_ctrl.cmd = DC_IGNORE;
                        n_state    = S_EMIT;
                    end
                endcase
            end
            S_SCAN: begin
                o_ctrl.cmd = DC_SCAN;
                if (!i_stat.trim) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_ctrl.cmd = DC_FINISH;
                n_state    = S_EMIT;
            end
            S_SWEEP: begin
                o_ctrl.cmd = DC_SWEEP;
                if (r_idx == LAST_IDX) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + t_idx'(1);
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.cmd = DC_EMIT;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (o_ctrl.cmd == DC_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/bapm_datapath.sv
// ----------------------------------------------------------------------------
// bapm_datapath
// slot flags, ages, ranks, free scan, destroy and create logic, result register
// ----------------------------------------------------------------------------
module bapm_datapath import bapm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_ctrl              i_ctrl,
    output t_dp_stat              o_stat,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [REL_W-1:0]      i_release_slot,
    input  logic                  i_purge,
    input  logic [DIM_W-1:0]      i_new_width,
    input  logic [DIM_W-1:0]      i_new_height,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_result               o_result
);

    // configuration
    logic [TRIM_W-1:0]  r_trim;
    logic [LIMIT_W-1:0] r_limit;

    // pool state
    logic [MAX_SLOTS-1:0] r_present;
    logic [MAX_SLOTS-1:0] r_busy;
    t_age                 r_age   [MAX_SLOTS];
    t_idx                 r_order [MAX_SLOTS];
    logic [CNT_W-1:0]     r_pool_count;
    t_idx                 r_cur_slot;
    logic                 r_cur_valid;
    logic [SURPLUS_W-1:0] r_surplus;
    t_idx                 r_best;
    logic                 r_found;

    // latched operation
    logic [OP_W-1:0]  r_op;
    logic [REL_W-1:0] r_rel;
    logic             r_purge;
    logic             r_size_zero;

    t_result r_res;
    t_result r_out;

    // free scan
    logic [CNT_W-1:0]     nfree;
    logic                 found;
    t_idx                 best;
    t_age                 lead_age;
    t_idx                 best_order;
    logic [SURPLUS_W-1:0] surplus_next;
    logic                 trim;

    always_comb begin
        nfree      = '0;
        found      = 1'b0;
        best       = '0;
        lead_age   = '0;
        best_order = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (r_present[i] && !r_busy[i]) begin
                nfree = nfree + CNT_W'(1);
                if (!found || r_age[i] > lead_age ||
                    (r_age[i] == lead_age && r_order[i] < best_order)) begin
                    found      = 1'b1;
                    best       = t_idx'(i);
                    lead_age   = r_age[i];
                    best_order = r_order[i];
                end
            end
        end
    end

    always_comb begin
        if (nfree >= CNT_W'(2)) begin
            surplus_next = (r_surplus == SURPLUS_MAX) ? r_surplus
                                                      : r_surplus + SURPLUS_W'(1);
        end else begin
            surplus_next = '0;
        end
    end

    assign trim = found && (surplus_next > r_trim);

    // destroy one slot
    logic drop_en;
    t_idx drop_idx;
    logic drop_live;

    always_comb begin
        drop_en  = 1'b0;
        drop_idx = best;
        case (i_ctrl.cmd)
            DC_SCAN: begin
                drop_en = trim;
            end
            DC_SWEEP: begin
                drop_idx = i_ctrl.idx;
                drop_en  = (r_op == OP_RECONFIG) || r_purge || !r_busy[i_ctrl.idx];
            end
            default: begin
                drop_en = 1'b0;
            end
        endcase
    end

    assign drop_live = drop_en && r_present[drop_idx];

    // create and pick
    logic [CNT_W-1:0] lim;
    logic             free_found;
    t_idx             free_idx;
    logic             can_make;
    logic             got;
    t_idx             pick;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (!r_present[i]) begin
                free_found = 1'b1;
                free_idx   = t_idx'(i);
            end
        end
    end

    assign lim      = (int'(r_limit) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(r_limit);
    assign can_make = !r_found && (r_pool_count < lim) && free_found;
    assign got      = r_found || can_make;
    assign pick     = r_found ? r_best : free_idx;

    // control and pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim       <= TRIM_RESET;
            r_limit      <= LIMIT_RESET;
            r_present    <= '0;
            r_busy       <= '0;
            r_pool_count <= '0;
            r_cur_slot   <= '0;
            r_cur_valid  <= 1'b0;
            r_surplus    <= '0;
            r_best       <= '0;
            r_found      <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TRIM:  r_trim  <= i_cfg_data[TRIM_W-1:0];
                    CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                    default:   r_trim  <= r_trim;
                endcase
            end
            case (i_ctrl.cmd)
                DC_SCAN: begin
                    if (trim) begin
                        r_surplus <= '0;
                    end else begin
                        r_surplus <= surplus_next;
                        r_best    <= best;
                        r_found   <= found;
                    end
                end
                DC_FINISH: begin
                    if (!got) begin
                        for (int i = 0; i < MAX_SLOTS; i++) begin
                            r_age[i] <= '0;
                        end
                        r_cur_valid <= 1'b0;
                    end else begin
                        for (int i = 0; i < MAX_SLOTS; i++) begin
                            if (r_present[i] && !(can_make && free_idx == t_idx'(i))) begin
                                r_age[i] <= age_inc(r_age[i]);
                            end
                        end
                        if (can_make) begin
                            r_present[free_idx] <= 1'b1;
                            r_busy[free_idx]    <= 1'b0;
                            r_age[free_idx]     <= '0;
                            r_pool_count        <= r_pool_count + CNT_W'(1);
                        end
                        r_cur_slot  <= pick;
                        r_cur_valid <= 1'b1;
                    end
                end
                DC_POST: begin
                    if (r_cur_valid) begin
                        r_busy[r_cur_slot] <= 1'b1;
                        r_age[r_cur_slot]  <= '0;
                        r_cur_valid        <= 1'b0;
                    end
                end
                DC_RELEASE: begin
                    r_busy[r_rel] <= 1'b0;
                end
                DC_SWEEP: begin
                    if (r_op == OP_RECONFIG &&
                        !(drop_live && r_cur_valid && r_cur_slot == drop_idx)) begin
                        r_cur_valid <= 1'b0;
                    end
                end
                default: begin
                    r_found <= r_found;
                end
            endcase
            if (drop_live) begin
                r_present[drop_idx] <= 1'b0;
                r_busy[drop_idx]    <= 1'b0;
                r_age[drop_idx]     <= '0;
                if (r_pool_count != '0) begin
                    r_pool_count <= r_pool_count - CNT_W'(1);
                end
                if (r_cur_valid && r_cur_slot == drop_idx) begin
                    r_cur_valid <= 1'b0;
                end
            end
        end
    end

    // allocation ranks, written on create before any read
    always_ff @(posedge i_clk) begin
        if (drop_live) begin
            for (int j = 0; j < MAX_SLOTS; j++) begin
                if (r_present[j] && r_order[j] > r_order[drop_idx]) begin
                    r_order[j] <= r_order[j] - t_idx'(1);
                end
            end
        end
        if (i_ctrl.cmd == DC_FINISH && can_make) begin
            r_order[free_idx] <= r_pool_count[IDX_W-1:0];
        end
    end

    // operation fields, working result and output register
    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            DC_LOAD: begin
                r_op        <= i_operation;
                r_rel       <= i_release_slot;
                r_purge     <= i_purge;
                r_size_zero <= (i_new_width == '0) || (i_new_height == '0);
                r_res       <= '0;
            end
            DC_FINISH: begin
                if (got) begin
                    r_res.slot       <= pick;
                    r_res.slot_valid <= 1'b1;
                    r_res.age        <= can_make ? '0 : age_inc(r_age[r_best]);
                    r_res.created    <= can_make;
                end else begin
                    r_res.status <= ST_NO_BUFFER;
                end
            end
            DC_POST: begin
                if (!r_cur_valid) begin
                    r_res.status <= ST_IGNORED;
                end
            end
            DC_IGNORE: begin
                r_res.status <= ST_IGNORED;
            end
            DC_EMIT: begin
                r_out <= r_res;
            end
            default: begin
                r_out <= r_out;
            end
        endcase
        if (drop_live) begin
            r_res.destroyed_mask[drop_idx] <= 1'b1;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.size_zero = r_size_zero;
    assign o_stat.trim      = trim;
    assign o_result         = r_out;

endmodule

// File: hw/rtl/buffer_age_pool_manager.sv
// ----------------------------------------------------------------------------
// buffer_age_pool_manager
// pool of render buffer slots with age based assign, trim, post, release,
// reconfigure and flush
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  i_in     sink       operation, release_slot, purge, new_width, new_height
//  o_out    source     status, slot, slot_valid, age, created, destroyed_mask
//  i_cfg    sink       index, data (0 trim_threshold, 1 buffer_limit)
//
//  an operation is taken one at a time: transfer, a decode state, then assign:
//  the scan state, repeated per trimmed buffer, and the finish state; post/
//  release/ignored: nothing more (done in decode); reconfigure/flush: the sweep,
//  one slot per cycle; then emit into o_out; slot loops: trim rescan, destroy sweep
//  a finished result sits in the output register; the next transfer on i_in
//  is taken meanwhile, and the one after waits until o_out is drained
//  synchronous active-low reset empties the pool; i_cfg is always ready
// ----------------------------------------------------------------------------
module buffer_age_pool_manager import bapm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bapm_in_if.sink    i_in,
    bapm_out_if.source o_out,
    bapm_cfg_if.sink   i_cfg
);

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;
    t_result  w_result;
    logic     w_in_ready;
    logic     w_out_valid;

    bapm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    bapm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .o_stat         (w_stat),
        .i_operation    (i_in.operation),
        .i_release_slot (i_in.release_slot),
        .i_purge        (i_in.purge),
        .i_new_width    (i_in.new_width),
        .i_new_height   (i_in.new_height),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_result       (w_result)
    );

    assign i_in.ready           = w_in_ready;
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = w_out_valid;
    assign o_out.status         = w_result.status;
    assign o_out.slot           = w_result.slot;
    assign o_out.slot_valid     = w_result.slot_valid;
    assign o_out.age            = w_result.age;
    assign o_out.created        = w_result.created;
    assign o_out.destroyed_mask = w_result.destroyed_mask;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("second operation taken while one is in flight");

    a_slot_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.slot_valid |-> o_out.status == ST_DONE)
        else $error("assigned slot with non-done status");

    a_no_buffer_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_NO_BUFFER |->
            !o_out.slot_valid && !o_out.created && o_out.age == '0)
        else $error("no-buffer result carries a slot");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.cmd == DC_EMIT |-> !o_out.valid || o_out.ready)
        else $error("result register overwritten before transfer");

endmodule

// File: tb/bapm_pool_checker.sv
// ----------------------------------------------------------------------------
// bapm_pool_checker
// Watches the operation, result and register write channels of the buffer age
// pool manager. It keeps its own copy of the pool and the register values,
// predicts the result of every accepted operation and compares each result
// transfer, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bapm_pool_checker import bapm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bapm_in_if   i_in,
    bapm_out_if  i_out,
    bapm_cfg_if  i_cfg,
    output int   o_mismatches,
    output int   o_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    logic                 slot_live  [MAX_SLOTS];
    logic                 slot_held  [MAX_SLOTS];
    t_age                 slot_age_q [MAX_SLOTS];
    t_idx                 slot_rank  [MAX_SLOTS];
    logic [CNT_W-1:0]     live_count;
    t_idx                 cur_slot;
    logic                 cur_valid;
    logic [SURPLUS_W-1:0] surplus_run;
    logic [TRIM_W-1:0]    trim_level;
    logic [LIMIT_W-1:0]   limit_level;
    logic [MAX_SLOTS-1:0] dropped;

    t_result awaited_results[$];
    int      mismatches = 0;
    int      awaited_n  = 0;

    assign o_mismatches = mismatches;
    assign o_awaited    = awaited_n;

    function automatic void destroy_buffer(input int s);
        if (!slot_live[s]) return;
        for (int j = 0; j < MAX_SLOTS; j++) begin
            if (slot_live[j] && slot_rank[j] > slot_rank[s]) slot_rank[j]--;
        end
        slot_live[s]  = 1'b0;
        slot_held[s]  = 1'b0;
        slot_age_q[s] = '0;
        if (live_count != 0) live_count--;
        dropped[s] = 1'b1;
        if (cur_valid && cur_slot == t_idx'(s)) cur_valid = 1'b0;
    endfunction

    function automatic int oldest_free(output int free_n);
        int pick;
        pick   = -1;
        free_n = 0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if (slot_live[s] && !slot_held[s]) begin
                free_n++;
                if (pick < 0 || slot_age_q[s] > slot_age_q[pick] ||
                    (slot_age_q[s] == slot_age_q[pick] && slot_rank[s] < slot_rank[pick]))
                    pick = s;
            end
        end
        return pick;
    endfunction

    function automatic t_result predict_pool_op(input logic [OP_W-1:0]  op,
                                                input logic [REL_W-1:0] rel,
                                                input logic             purge,
                                                input logic [DIM_W-1:0] w,
                                                input logic [DIM_W-1:0] h);
        t_result r;
        int      best;
        int      made;
        int      free_n;
        int      cap;
        r       = '0;
        r.status = ST_DONE;
        dropped = '0;
        case (op)
            OP_ASSIGN: begin
                made = -1;
                best = -1;
                cap  = (int'(limit_level) < MAX_SLOTS) ? int'(limit_level) : MAX_SLOTS;
                for (int pass = 0; pass <= MAX_SLOTS; pass++) begin
                    best = oldest_free(free_n);
                    if (free_n >= 2)
                        surplus_run = (surplus_run == SURPLUS_MAX) ? surplus_run
                                                                   : surplus_run + 1'b1;
                    else
                        surplus_run = '0;
                    if (best >= 0 && surplus_run > trim_level) begin
                        surplus_run = '0;
                        destroy_buffer(best);
                        best = -1;
                    end else begin
                        break;
                    end
                end
                if (best < 0 && int'(live_count) < cap) begin
                    for (int s = 0; s < MAX_SLOTS; s++) begin
                        if (!slot_live[s]) begin
                            slot_live[s]  = 1'b1;
                            slot_held[s]  = 1'b0;
                            slot_age_q[s] = '0;
                            slot_rank[s]  = t_idx'(live_count);
                            live_count++;
                            made = s;
                            best = s;
                            break;
                        end
                    end
                end
                if (best < 0) begin
                    for (int s = 0; s < MAX_SLOTS; s++) slot_age_q[s] = '0;
                    cur_valid = 1'b0;
                    r.status  = ST_NO_BUFFER;
                end else begin
                    for (int s = 0; s < MAX_SLOTS; s++) begin
                        if (slot_live[s] && s != made && slot_age_q[s] != AGE_MAX)
                            slot_age_q[s] = slot_age_q[s] + 1'b1;
                    end
                    cur_slot     = t_idx'(best);
                    cur_valid    = 1'b1;
                    r.slot       = t_idx'(best);
                    r.slot_valid = 1'b1;
                    r.age        = slot_age_q[best];
                    r.created    = (made >= 0);
                end
            end
            OP_POST: begin
                if (!cur_valid) begin
                    r.status = ST_IGNORED;
                end else begin
                    slot_held[cur_slot]  = 1'b1;
                    slot_age_q[cur_slot] = '0;
                    cur_valid            = 1'b0;
                end
            end
            OP_RELEASE: begin
                slot_held[rel] = 1'b0;
            end
            OP_RECONFIG: begin
                if (w == '0 || h == '0) begin
                    r.status = ST_IGNORED;
                end else begin
                    for (int s = 0; s < MAX_SLOTS; s++) destroy_buffer(s);
                    cur_valid = 1'b0;
                end
            end
            OP_FLUSH: begin
                for (int s = 0; s < MAX_SLOTS; s++) begin
                    if (purge || !slot_held[s]) destroy_buffer(s);
                end
            end
            default: r.status = ST_IGNORED;
        endcase
        r.destroyed_mask = dropped;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_SLOTS; s++) begin
                slot_live[s]  = 1'b0;
                slot_held[s]  = 1'b0;
                slot_age_q[s] = '0;
                slot_rank[s]  = '0;
            end
            live_count  = '0;
            cur_slot    = '0;
            cur_valid   = 1'b0;
            surplus_run = '0;
            trim_level  = TRIM_RESET;
            limit_level = LIMIT_RESET;
            awaited_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_TRIM)
                    trim_level = i_cfg.data[TRIM_W-1:0];
                else if (i_cfg.index == CFG_LIMIT)
                    limit_level = i_cfg.data[LIMIT_W-1:0];
            end
            if (i_out.valid && i_out.ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result transfer, expected none, actual status %0d slot %0d",
                             $time, i_out.status, i_out.slot);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, i_out.status);
                    check_field("slot", want.slot, i_out.slot);
                    check_field("slot_valid", want.slot_valid, i_out.slot_valid);
                    check_field("age", want.age, i_out.age);
                    check_field("created", want.created, i_out.created);
                    check_field("destroyed_mask", want.destroyed_mask, i_out.destroyed_mask);
                end
            end
            if (i_in.valid && i_in.ready)
                awaited_results.push_back(predict_pool_op(i_in.operation, i_in.release_slot,
                                                          i_in.purge, i_in.new_width,
                                                          i_in.new_height));
        end
        awaited_n <= awaited_results.size();
    end

endmodule

// File: tb/buffer_age_pool_manager_tb.sv
// ----------------------------------------------------------------------------
// buffer_age_pool_manager_tb
// Drives operations and register writes into the buffer age pool manager with
// random gaps on the sender and random stalls on the receiver, including long
// hold-offs that back the block up. A directed run covers the edge cases, an
// aging run drives buffer ages and the surplus count into saturation, and
// random frame sequences run under several register settings. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module buffer_age_pool_manager_tb import bapm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_OFF       = 300;
    localparam int PHASES         = 6;
    localparam int MIX_ITEMS      = 50;

    localparam logic [OP_W-1:0]      OP_SPARE_FIRST = OP_FLUSH + 1'b1;
    localparam logic [OP_W-1:0]      OP_SPARE_LAST  = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = '1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   mismatch_count;
    int   awaited_count;
    int   send_calm = 0;

    bapm_in_if  in_ch ();
    bapm_out_if out_ch ();
    bapm_cfg_if cfg_ch ();

    buffer_age_pool_manager dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    bapm_pool_checker pool_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatch_count),
        .o_awaited    (awaited_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int gap_len(inout int calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (roll < 3) calm = $urandom_range(20, 60);
        if (roll < 50) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_op(input logic [OP_W-1:0]  op,
                           input logic [REL_W-1:0] rel,
                           input logic             purge,
                           input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h);
        int gap;
        gap = gap_len(send_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= op;
        in_ch.release_slot <= rel;
        in_ch.purge        <= purge;
        in_ch.new_width    <= w;
        in_ch.new_height   <= h;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic issue_op(input logic [OP_W-1:0] op);
        send_op(op, REL_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                DIM_W'($urandom), DIM_W'($urandom));
    endtask

    task automatic release_slot(input logic [REL_W-1:0] rel);
        send_op(OP_RELEASE, rel, 1'($urandom_range(0, 1)), DIM_W'($urandom),
                DIM_W'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle_pool();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (awaited_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [OP_W-1:0] OP_WIDTH_SPARE();
        return OP_W'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));
    endfunction

    // frame sequences with random content, plus stray and broken operations
    task automatic run_mix(input int n);
        int sent;
        int roll;
        int pick;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        sent = 0;
        while (sent < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                issue_op(OP_ASSIGN);
                sent++;
                if ($urandom_range(0, 3) != 0) begin
                    issue_op(OP_POST);
                    sent++;
                end
                if ($urandom_range(0, 1) == 0) begin
                    issue_op(OP_RELEASE);
                    sent++;
                end
            end else if (roll < 74) begin
                issue_op(OP_RELEASE);
                sent++;
            end else if (roll < 82) begin
                issue_op(OP_FLUSH);
                sent++;
            end else if (roll < 90) begin
                pick = $urandom_range(0, 5);
                w = (pick == 0 || pick == 2) ? '0 : DIM_W'($urandom);
                h = (pick == 1 || pick == 2) ? '0 : DIM_W'($urandom);
                send_op(OP_RECONFIG, REL_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        w, h);
                sent++;
            end else if (roll < 95) begin
                issue_op(OP_POST);
                sent++;
            end else begin
                issue_op(OP_WIDTH_SPARE());
                sent++;
            end
        end
    endtask

    // keep one buffer busy while the free ones are assigned over and over
    task automatic age_out_pool();
        write_reg(CFG_TRIM, '1);
        write_reg(CFG_LIMIT, CFG_DATA_W'(3));
        send_op(OP_RECONFIG, 2'd0, 1'b0, DIM_W'($urandom_range(1, 65535)),
                DIM_W'($urandom_range(1, 65535)));
        repeat (3) begin
            issue_op(OP_ASSIGN);
            issue_op(OP_POST);
        end
        release_slot(2'd1);
        release_slot(2'd2);
        repeat (int'(AGE_MAX) + 5) issue_op(OP_ASSIGN);
        release_slot(2'd0);
        issue_op(OP_ASSIGN);
        settle_pool();
    endtask

    // receiver
    initial begin
        int stall;
        int cycles;
        int calm;
        out_ch.ready <= 1'b0;
        stall  = 0;
        cycles = 0;
        calm   = 0;
        forever begin
            @(negedge i_clk);
            cycles++;
            if (cycles == 2500 || cycles == 7000)
                stall = HOLD_OFF;
            else if (stall == 0 && $urandom_range(0, 3) == 0)
                stall = gap_len(calm);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // stimulus
    initial begin
        logic [TRIM_W-1:0]     trim_plan  [PHASES];
        logic [CFG_DATA_W-1:0] limit_plan [PHASES];
        trim_plan  = '{8'd0, 8'd255, 8'd3, 8'd1, 8'd10, 8'd0};
        limit_plan = '{8'd4, 8'd7, 8'd2, 8'd0, 8'hF9, 8'd0};
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= OP_ASSIGN;
        in_ch.release_slot <= '0;
        in_ch.purge        <= 1'b0;
        in_ch.new_width    <= '0;
        in_ch.new_height   <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_TRIM;
        cfg_ch.data        <= '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed edge cases under reset register values
        issue_op(OP_POST);
        release_slot(2'd3);
        issue_op(OP_ASSIGN);
        issue_op(OP_ASSIGN);
        issue_op(OP_POST);
        issue_op(OP_ASSIGN);
        issue_op(OP_POST);
        issue_op(OP_ASSIGN);
        issue_op(OP_ASSIGN);
        issue_op(OP_POST);
        issue_op(OP_ASSIGN);
        issue_op(OP_POST);
        issue_op(OP_ASSIGN);
        release_slot(2'd0);
        release_slot(2'd1);
        issue_op(OP_ASSIGN);
        send_op(OP_FLUSH, 2'd2, 1'b0, 16'hFFFF, 16'hFFFF);
        issue_op(OP_POST);
        send_op(OP_RECONFIG, 2'd1, 1'b1, 16'h0000, 16'hFFFF);
        send_op(OP_RECONFIG, 2'd2, 1'b0, 16'hFFFF, 16'h0000);
        send_op(OP_RECONFIG, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF);
        issue_op(OP_ASSIGN);
        send_op(OP_FLUSH, 2'd0, 1'b1, 16'h0000, 16'h0000);
        for (int c = int'(OP_SPARE_FIRST); c <= int'(OP_SPARE_LAST); c++)
            issue_op(OP_W'(c));
        settle_pool();

        age_out_pool();

        trim_plan[PHASES-1]  = TRIM_W'($urandom);
        limit_plan[PHASES-1] = CFG_DATA_W'($urandom_range(1, 4));
        for (int p = 0; p < PHASES; p++) begin
            if (p == 2) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            write_reg(CFG_TRIM, trim_plan[p]);
            write_reg(CFG_LIMIT, limit_plan[p]);
            run_mix(MIX_ITEMS);
            settle_pool();
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
